FILE: src/smmc_pkg.sv
// shared constants and types for the sensor min/max calibration block
package smmc_pkg;

	localparam int NUM_SENSORS   = 8;
	localparam int SAMPLE_BITS   = 12;
	localparam int SENSOR_FIELDS = 8;
	localparam int FIELD_W       = 12;
	localparam int TIME_W        = 32;
	localparam int THR_W         = 12;
	localparam int S_TDATA_W     = 128;
	localparam int M_TDATA_W     = 16;

	localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
	localparam logic [SAMPLE_BITS-1:0] MAX_RESET  = SAMPLE_BITS'(4095) & FULL_SCALE;
	localparam logic [TIME_W-1:0]      DURATION_RESET = TIME_W'(10000);

	// sum of midpoints never overflows this width
	localparam int SUM_W = SAMPLE_BITS + $clog2(NUM_SENSORS);

	// mean by reciprocal multiply: floor(sum * DIV_MUL >> DIV_SHIFT) is exact
	localparam int    DIV_SHIFT = SUM_W + $clog2(NUM_SENSORS);
	localparam longint DIV_MUL_L = ((64'd1 << DIV_SHIFT) + NUM_SENSORS - 1) / NUM_SENSORS;
	localparam logic [DIV_SHIFT:0] DIV_MUL = DIV_MUL_L[DIV_SHIFT:0];
	localparam int    PROD_W = SUM_W + DIV_SHIFT + 1;

	typedef logic [SAMPLE_BITS-1:0] sample_t;
	typedef logic [SUM_W-1:0]       sum_t;

	typedef enum logic {
		ACT_SAMPLE = 1'b0,
		ACT_START  = 1'b1
	} action_t;

	// per-lane update strobes
	typedef struct packed {
		logic start;
		logic update;
	} lane_ctl_t;

endpackage

FILE: src/smmc_lane.sv
// one sensor lane: running minimum and maximum and their midpoint
module smmc_lane (
	input  logic                clk,
	input  logic                arst_n,
	input  smmc_pkg::lane_ctl_t ctl,
	input  smmc_pkg::sample_t   reading,
	output smmc_pkg::sample_t   mid
);
	import smmc_pkg::*;

	sample_t min_q;
	sample_t max_q;
	logic [SAMPLE_BITS:0] pair_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= MAX_RESET;
		end else if (ctl.start) begin
			min_q <= FULL_SCALE;
			max_q <= '0;
		end else if (ctl.update) begin
			if (reading < min_q) begin
				min_q <= reading;
			end
			if (reading > max_q) begin
				max_q <= reading;
			end
		end
	end

	assign pair_sum = {1'b0, min_q} + {1'b0, max_q};
	assign mid      = pair_sum[SAMPLE_BITS:1];

endmodule

FILE: src/smmc_merge.sv
// merging stage: sums lane midpoints and divides by the lane count
module smmc_merge (
	input  logic              clk,
	input  logic              load,
	input  smmc_pkg::sample_t mid [smmc_pkg::NUM_SENSORS],
	output smmc_pkg::sample_t mean
);
	import smmc_pkg::*;

	sum_t              sum_d;
	sum_t              sum_s2;
	logic [PROD_W-1:0] prod;

	always_comb begin
		sum_d = '0;
		for (int i = 0; i < NUM_SENSORS; i++) begin
			sum_d = sum_d + SUM_W'(mid[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sum_s2 <= sum_d;
		end
	end

	// constant reciprocal, exact for every sum below 2**SUM_W
	assign prod = PROD_W'(sum_s2) * PROD_W'(DIV_MUL);
	assign mean = prod[DIV_SHIFT +: SAMPLE_BITS];

endmodule

FILE: src/sensor_min_max_calibration.sv
// top level of the sensor min/max calibration block
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tuser: action; tdata: now_ms, sensor_0..sensor_7
//  m_*       out  m_tvalid/m_tready  tuser: calibrating, finished; tdata: threshold
//  cfg_*     in   cfg_we             cfg_wdata: duration_ms
//
// one request accepted per cycle unless m_tready back-pressure fills the stages;
// the lane min/max registers update at the accept edge, the midpoint sum is
// registered one stage later and the constant-reciprocal divide feeds the output register
// every stage holds independently when the stage after it is full, so bubbles collapse
// and a new request is taken while a finished result waits on m_tready
// reset clears flags and threshold, duration to default, lane min 0, max all ones; no clearing pass
module sensor_min_max_calibration (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [smmc_pkg::S_TDATA_W-1:0] s_tdata,   // now_ms[31:0], sensor_0 .. sensor_7 (12 bit each)
	input  logic                           s_tuser,   // action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [smmc_pkg::M_TDATA_W-1:0] m_tdata,   // threshold[11:0], zero pad
	output logic [1:0]                     m_tuser,   // calibrating, finished
	input  logic                           cfg_we,
	input  logic [smmc_pkg::TIME_W-1:0]    cfg_wdata  // duration_ms
);
	import smmc_pkg::*;

	// request fields
	logic              accept;
	logic              is_start;
	logic [TIME_W-1:0] now_ms;
	logic [TIME_W-1:0] elapsed;
	logic              done_d;
	logic              cal_d;

	// control state
	logic [TIME_W-1:0] duration_q;
	logic [TIME_W-1:0] start_time_q;
	logic              active_q;
	sample_t           thr_q;

	// pipeline
	logic    s1_v, s1_cal, s1_done;
	logic    s2_v, s2_cal, s2_done;
	logic    out_v_q, out_cal_q, out_done_q;
	sample_t out_thr_q;
	logic    out_ready, s2_ready, s1_ready;

	// lanes
	lane_ctl_t lane_ctl;
	sample_t   reading [NUM_SENSORS];
	sample_t   mid     [NUM_SENSORS];
	sample_t   mean;

	assign out_ready = !out_v_q || m_tready;
	assign s2_ready  = !s2_v || out_ready;
	assign s1_ready  = !s1_v || s2_ready;
	assign s_tready  = s1_ready;
	assign accept    = s_tvalid && s_tready;

	assign is_start = (action_t'(s_tuser) == ACT_START);
	assign now_ms   = s_tdata[TIME_W-1:0];
	assign elapsed  = now_ms - start_time_q;

	// the elapsed check only applies to samples taken while calibrating
	assign done_d = !is_start && active_q && (elapsed >= duration_q);
	assign cal_d  = is_start || (active_q && !done_d);

	assign lane_ctl.start  = accept && is_start;
	assign lane_ctl.update = accept && !is_start && active_q;

	// lane readings; lanes beyond the input fields read zero
	for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
		if (g < SENSOR_FIELDS) begin : g_field
			assign reading[g] = SAMPLE_BITS'(s_tdata[TIME_W + FIELD_W*g +: FIELD_W]);
		end else begin : g_zero
			assign reading[g] = '0;
		end

		smmc_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (lane_ctl),
			.reading (reading[g]),
			.mid     (mid[g])
		);
	end

	// lane registers hold this request's extremes while it sits in stage 1
	smmc_merge u_merge (
		.clk  (clk),
		.load (s1_v && s2_ready),
		.mid  (mid),
		.mean (mean)
	);

	// configuration and calibration state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duration_q   <= DURATION_RESET;
			start_time_q <= '0;
			active_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				duration_q <= cfg_wdata;
			end
			if (accept) begin
				active_q <= cal_d;
				if (is_start) begin
					start_time_q <= now_ms;
				end
			end
		end
	end

	// stage 1 and stage 2 flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s1_cal  <= 1'b0;
			s1_done <= 1'b0;
			s2_v    <= 1'b0;
			s2_cal  <= 1'b0;
			s2_done <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_v    <= accept;
				s1_cal  <= cal_d;
				s1_done <= done_d;
			end
			if (s2_ready) begin
				s2_v    <= s1_v;
				s2_cal  <= s1_cal;
				s2_done <= s1_done;
			end
		end
	end

	// output register; the threshold follows the last finish in request order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			out_cal_q  <= 1'b0;
			out_done_q <= 1'b0;
			out_thr_q  <= '0;
			thr_q      <= '0;
		end else if (out_ready) begin
			out_v_q <= s2_v;
			if (s2_v) begin
				out_cal_q  <= s2_cal;
				out_done_q <= s2_done;
				if (s2_done) begin
					out_thr_q <= mean;
					thr_q     <= mean;
				end else begin
					out_thr_q <= thr_q;
				end
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = {out_done_q, out_cal_q};
	assign m_tdata  = M_TDATA_W'(THR_W'(out_thr_q));

endmodule
